// ===== design/mbr_pkg.sv =====
`timescale 1ns / 1ps
package mbr_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = 10;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] FAR_SPLIT  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_ADD    = IDX_W'(TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_SUB    = IDX_W'(STATE_WORDS - TWIST_OFFSET);

  localparam logic [31:0] SEED_MULT  = 32'h0001_0DCD;
  localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [31:0] RESET_SEED = 32'h0000_0001;

  typedef enum logic [2:0] {
    FS_FILL,
    FS_IDLE,
    FS_RA,
    FS_RB,
    FS_RC,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_OUT
  } back_state_t;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] bound;
  } draw_t;

  function automatic logic [31:0] mix(input logic [31:0] hi, input logic [31:0] lo,
                                      input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] r;
    y = {hi[31], lo[30:0]};
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ MATRIX_A;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== design/mt19937_bounded_random_top.sv =====
`timescale 1ns / 1ps
// channel | handshake            | payload
// cfg     | cfg_we               | cfg_wdata (seed, 32 bits)
// in      | in_valid / in_ready  | bound (32 bits)
// out     | out_valid / out_ready| value (32 bits)
//
// front: one item at a time, three reads of the table's single read port plus one write per item
// back: a 32-step remainder (word mod bound) for a nonzero bound; bound 0 passes the word through
// a two-entry queue parts front and back; with nonzero bounds the back sets the sustained rate
// after reset and after each seed write the table refill writes all 624 words,
// in_ready stays low meanwhile
module mt19937_bounded_random_top
  import mbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] bound,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  logic  push;
  logic  full;
  logic  pop;
  logic  nonempty;
  draw_t push_item;
  draw_t pop_item;

  mbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .bound     (bound),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  mbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .nonempty  (nonempty)
  );

  mbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

endmodule

// ===== design/mbr_ram.sv =====
`timescale 1ns / 1ps
module mbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mbr_front.sv =====
`timescale 1ns / 1ps
module mbr_front
  import mbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] bound,
  output logic        push,
  output draw_t       push_item,
  input  logic        full
);

  front_state_t     state, state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_p1;
  logic [IDX_W-1:0] far_idx;
  logic [IDX_W-1:0] fill_cnt;
  logic [31:0]      fill_word;
  logic [31:0]      hi_word;
  logic [31:0]      lo_word;
  logic [31:0]      new_word;
  logic [31:0]      bound_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  mbr_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_p1  = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  assign far_idx = (idx < FAR_SPLIT) ? idx + FAR_ADD : idx - FAR_SUB;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_FILL;
      idx       <= '0;
      fill_cnt  <= '0;
      fill_word <= RESET_SEED;
    end else if (cfg_we) begin
      state     <= FS_FILL;
      idx       <= '0;
      fill_cnt  <= '0;
      fill_word <= cfg_wdata;
    end else begin
      state <= state_next;
      if (state == FS_FILL) begin
        fill_cnt  <= fill_cnt + IDX_W'(1);
        fill_word <= 32'(fill_word * SEED_MULT);
      end
      if (state == FS_PUSH && !full) begin
        idx <= idx_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bound_q <= bound;
    end
    if (state == FS_RA) begin
      hi_word <= ram_rdata;
    end
    if (state == FS_RB) begin
      lo_word <= ram_rdata;
    end
    if (state == FS_RC) begin
      new_word <= mix(hi_word, lo_word, ram_rdata);
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = mix(hi_word, lo_word, ram_rdata);
    ram_raddr  = idx;
    case (state)
      FS_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt;
        ram_wdata = fill_word;
        if (fill_cnt == LAST_IDX) begin
          state_next = FS_IDLE;
        end
      end
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = FS_RA;
        end
      end
      FS_RA: begin
        ram_raddr  = idx_p1;
        state_next = FS_RB;
      end
      FS_RB: begin
        ram_raddr  = far_idx;
        state_next = FS_RC;
      end
      FS_RC: begin
        ram_we     = 1'b1;
        state_next = FS_PUSH;
      end
      FS_PUSH: begin
        push = !full;
        if (!full) begin
          state_next = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_FILL;
      end
    endcase
  end

  assign push_item.word  = temper(new_word);
  assign push_item.bound = bound_q;

endmodule

// ===== design/mbr_queue.sv =====
`timescale 1ns / 1ps
module mbr_queue
  import mbr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  draw_t push_item,
  output logic  full,
  input  logic  pop,
  output draw_t pop_item,
  output logic  nonempty
);

  draw_t       slots [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// ===== design/mbr_back.sv =====
`timescale 1ns / 1ps
module mbr_back
  import mbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        nonempty,
  input  draw_t       pop_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] value
);

  back_state_t state, state_next;
  logic [31:0] dividend;
  logic [31:0] divisor;
  logic [31:0] rem;
  logic [4:0]  step;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, dividend[31]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == BS_DIV) begin
        step <= step + 5'd1;
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BS_IDLE && nonempty) begin
      dividend <= pop_item.word;
      divisor  <= pop_item.bound;
      rem      <= '0;
      value    <= pop_item.word;
    end else if (state == BS_DIV) begin
      dividend <= dividend << 1;
      if (!diff[32]) begin
        rem <= diff[31:0];
      end else begin
        rem <= trial[31:0];
      end
      if (step == 5'd31) begin
        value <= !diff[32] ? diff[31:0] : trial[31:0];
      end
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = 1'b0;
    case (state)
      BS_IDLE: begin
        if (nonempty) begin
          pop        = 1'b1;
          state_next = (pop_item.bound == '0) ? BS_OUT : BS_DIV;
        end
      end
      BS_DIV: begin
        if (step == 5'd31) begin
          state_next = BS_OUT;
        end
      end
      BS_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = BS_IDLE;
        end
      end
      default: begin
        state_next = BS_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mbr_checker.sv =====
`timescale 1ns / 1ps
module mbr_props (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result changed while stalled");

  a_reset_fill: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("ready during refill after reset");

  a_seed_fill: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("ready during refill after seed write");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while first is in the table stage");

endmodule

bind mt19937_bounded_random_top mbr_props u_mbr_props (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value)
);
